FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: design/rti_pkg.sv
`timescale 1ns / 1ps
package rti_pkg;

    localparam int COORD_BITS = 21;
    localparam int DIST_BITS  = 32;
    localparam int DIST_FRAC  = DIST_BITS / 2;
    localparam int REG_W      = 63;
    localparam int IDX_W      = 2;
    // Edge and difference vectors need one bit more than a coordinate.
    localparam int EW         = COORD_BITS + 1;
    localparam int PW         = 2 * EW;
    localparam int XW         = PW + 1;
    localparam int MW         = XW + EW;
    localparam int DW         = MW + 2;

    typedef enum logic [IDX_W-1:0] {
        REG_APEX  = 2'd0,
        REG_LEFT  = 2'd1,
        REG_RIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] origin_packed;
        logic [REG_W-1:0] direction_packed;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic [DIST_BITS-1:0] distance;
    } t_out;

    typedef struct packed {
        logic                 valid;
        logic signed [DW-1:0] det;
        logic signed [DW-1:0] un;
        logic signed [DW-1:0] vn;
        logic signed [DW-1:0] tn;
    } t_dots;

    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic                 sat;
        logic [DW-1:0]        rem;
        logic [DW-1:0]        den;
        logic [DIST_BITS-1:0] nbits;
    } t_divin;

    // Coordinate k of a packed vector, widened to edge width.
    function automatic logic signed [EW-1:0] coord(input logic [REG_W-1:0] v,
                                                   input int k);
        logic signed [COORD_BITS-1:0] c;
        c = v[k*COORD_BITS +: COORD_BITS];
        return EW'(c);
    endfunction

endpackage

FILE: design/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// ray       in         i_start / o_busy    i_item (origin, direction)
// result    out        o_valid strobe      o_result (hit, distance)
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A ray is taken in every cycle; o_busy is never raised.
// Each result passes through five stages of edge, cross and dot arithmetic, two of
// sign and hit tests, 32 of restoring division (one quotient bit each) and the
// output register.
// Synchronous active-low reset clears the vertices and all valid bits.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"
module ray_triangle_intersect import rti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_in              i_item,
    output logic             o_valid,
    output t_out             o_result,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    logic [REG_W-1:0] r_apex, r_left, r_right;
    t_dots            w_dots;
    t_divin           w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apex  <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_APEX:  r_apex  <= i_cfg_data;
                REG_LEFT:  r_left  <= i_cfg_data;
                REG_RIGHT: r_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    rti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_item  (i_item),
        .i_apex  (r_apex),
        .i_left  (r_left),
        .i_right (r_right),
        .o_dots  (w_dots)
    );

    rti_test u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dots  (w_dots),
        .o_div   (w_div)
    );

    rti_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_div    (w_div),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_valid && !o_result.hit, o_result.distance == '0, "miss with nonzero distance")
    `ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy, "pipeline reported busy")

endmodule

FILE: design/rti_geom.sv
`timescale 1ns / 1ps
module rti_geom import rti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in              i_item,
    input  logic [REG_W-1:0] i_apex,
    input  logic [REG_W-1:0] i_left,
    input  logic [REG_W-1:0] i_right,
    output t_dots            o_dots
);

    logic [4:0] r_v;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [EW-1:0] r_d1 [3];
    logic signed [EW-1:0] r_t1 [3];
    logic signed [EW-1:0] r_d2 [3];
    logic signed [EW-1:0] r_t2 [3];
    logic signed [EW-1:0] r_d3 [3];
    logic signed [EW-1:0] r_t3 [3];
    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    logic signed [PW-1:0] r_qa [3];
    logic signed [PW-1:0] r_qb [3];
    logic signed [XW-1:0] r_p  [3];
    logic signed [XW-1:0] r_q  [3];
    logic signed [MW-1:0] r_mdet [3];
    logic signed [MW-1:0] r_mu   [3];
    logic signed [MW-1:0] r_mv   [3];
    logic signed [MW-1:0] r_mt   [3];
    logic signed [DW-1:0] r_det, r_un, r_vn, r_tn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            // Edges follow the vertex registers; the user must change them only while idle (not enforced here).
            r_e1[k] <= coord(i_left, k) - coord(i_apex, k);
            r_e2[k] <= coord(i_right, k) - coord(i_apex, k);
            r_d1[k] <= coord(i_item.direction_packed, k);
            r_t1[k] <= coord(i_item.origin_packed, k) - coord(i_apex, k);
            r_d2[k] <= r_d1[k];
            r_t2[k] <= r_t1[k];
            r_d3[k] <= r_d2[k];
            r_t3[k] <= r_t2[k];
            r_p[k]  <= XW'(r_pa[k]) - XW'(r_pb[k]);
            r_q[k]  <= XW'(r_qa[k]) - XW'(r_qb[k]);
            r_mdet[k] <= MW'(r_p[k]) * MW'(r_e1[k]);
            r_mu[k]   <= MW'(r_p[k]) * MW'(r_t3[k]);
            r_mv[k]   <= MW'(r_q[k]) * MW'(r_d3[k]);
            r_mt[k]   <= MW'(r_q[k]) * MW'(r_e2[k]);
        end
        // P = D x E2, Q = T x E1
        r_pa[0] <= PW'(r_d1[1]) * PW'(r_e2[2]);
        r_pb[0] <= PW'(r_d1[2]) * PW'(r_e2[1]);
        r_pa[1] <= PW'(r_d1[2]) * PW'(r_e2[0]);
        r_pb[1] <= PW'(r_d1[0]) * PW'(r_e2[2]);
        r_pa[2] <= PW'(r_d1[0]) * PW'(r_e2[1]);
        r_pb[2] <= PW'(r_d1[1]) * PW'(r_e2[0]);
        r_qa[0] <= PW'(r_t1[1]) * PW'(r_e1[2]);
        r_qb[0] <= PW'(r_t1[2]) * PW'(r_e1[1]);
        r_qa[1] <= PW'(r_t1[2]) * PW'(r_e1[0]);
        r_qb[1] <= PW'(r_t1[0]) * PW'(r_e1[2]);
        r_qa[2] <= PW'(r_t1[0]) * PW'(r_e1[1]);
        r_qb[2] <= PW'(r_t1[1]) * PW'(r_e1[0]);
        r_det <= DW'(r_mdet[0]) + DW'(r_mdet[1]) + DW'(r_mdet[2]);
        r_un  <= DW'(r_mu[0]) + DW'(r_mu[1]) + DW'(r_mu[2]);
        r_vn  <= DW'(r_mv[0]) + DW'(r_mv[1]) + DW'(r_mv[2]);
        r_tn  <= DW'(r_mt[0]) + DW'(r_mt[1]) + DW'(r_mt[2]);
    end

    assign o_dots.valid = r_v[4];
    assign o_dots.det   = r_det;
    assign o_dots.un    = r_un;
    assign o_dots.vn    = r_vn;
    assign o_dots.tn    = r_tn;

endmodule

FILE: design/rti_test.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rti_test import rti_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_dots  i_dots,
    output t_divin o_div
);

    logic                 r_v6, r_zero;
    logic signed [DW-1:0] r_det, r_un, r_vn, r_tn;
    t_divin               r_out;
    logic [DW:0]          w_uv;
    logic [DW+DIST_FRAC-1:0] w_tn_w, w_det_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= i_dots.valid;
        end
    end

    // Fold the sign of the determinant into the numerators.
    always_ff @(posedge i_clk) begin
        r_zero <= (i_dots.det == '0);
        if (i_dots.det < 0) begin
            r_det <= -i_dots.det;
            r_un  <= -i_dots.un;
            r_vn  <= -i_dots.vn;
            r_tn  <= -i_dots.tn;
        end else begin
            r_det <= i_dots.det;
            r_un  <= i_dots.un;
            r_vn  <= i_dots.vn;
            r_tn  <= i_dots.tn;
        end
    end

    assign w_uv    = (DW+1)'(unsigned'(r_un)) + (DW+1)'(unsigned'(r_vn));
    assign w_tn_w  = (DW+DIST_FRAC)'(unsigned'(r_tn));
    assign w_det_w = {unsigned'(r_det), {DIST_FRAC{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_v6;
        end
        r_out.hit   <= !r_zero && (r_un >= 0) && (r_vn >= 0)
                       && (w_uv < (DW+1)'(unsigned'(r_det))) && (r_tn > 0);
        r_out.sat   <= (w_tn_w >= w_det_w);
        r_out.rem   <= unsigned'(r_tn) >> DIST_FRAC;
        r_out.den   <= unsigned'(r_det);
        r_out.nbits <= {r_tn[DIST_FRAC-1:0], {(DIST_BITS-DIST_FRAC){1'b0}}};
    end

    assign o_div = r_out;

    `ASSERT_IMPLY(a_hit_den_nonzero, i_clk, i_rst_n, r_out.valid && r_out.hit, r_out.den != '0, "hit with zero determinant")

endmodule

FILE: design/rti_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rti_div import rti_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_divin i_div,
    output logic   o_valid,
    output t_out   o_result
);

    // One quotient bit per stage, most significant first.
    logic                 r_v   [1:DIST_BITS];
    logic                 r_hit [1:DIST_BITS];
    logic                 r_sat [1:DIST_BITS];
    logic [DW-1:0]        r_rem [1:DIST_BITS];
    logic [DW-1:0]        r_den [1:DIST_BITS];
    logic [DIST_BITS-1:0] r_nb  [1:DIST_BITS];
    logic [DIST_BITS-1:0] r_q   [1:DIST_BITS];
    logic                 r_ov;
    t_out                 r_res;

    for (genvar g = 0; g < DIST_BITS; g++) begin : g_stage
        logic                 w_v, w_hit, w_sat;
        logic [DW-1:0]        w_rem, w_den;
        logic [DIST_BITS-1:0] w_nb, w_q;
        logic [DW:0]          w_trial;
        logic                 w_ge;

        if (g == 0) begin : g_head
            assign w_v   = i_div.valid;
            assign w_hit = i_div.hit;
            assign w_sat = i_div.sat;
            assign w_rem = i_div.rem;
            assign w_den = i_div.den;
            assign w_nb  = i_div.nbits;
            assign w_q   = '0;
        end else begin : g_body
            assign w_v   = r_v[g];
            assign w_hit = r_hit[g];
            assign w_sat = r_sat[g];
            assign w_rem = r_rem[g];
            assign w_den = r_den[g];
            assign w_nb  = r_nb[g];
            assign w_q   = r_q[g];
        end

        assign w_trial = {w_rem, w_nb[DIST_BITS-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_hit[g+1] <= w_hit;
            r_sat[g+1] <= w_sat;
            r_den[g+1] <= w_den;
            r_nb[g+1]  <= w_nb << 1;
            r_q[g+1]   <= {w_q[DIST_BITS-2:0], w_ge};
            r_rem[g+1] <= w_ge ? DW'(w_trial - {1'b0, w_den}) : DW'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[DIST_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.hit <= r_hit[DIST_BITS];
        if (!r_hit[DIST_BITS]) begin
            r_res.distance <= '0;
        end else if (r_sat[DIST_BITS]) begin
            r_res.distance <= '1;
        end else begin
            r_res.distance <= r_q[DIST_BITS];
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

    `ASSERT_IMPLY(a_rem_below_den, i_clk, i_rst_n, r_v[DIST_BITS] && r_hit[DIST_BITS] && !r_sat[DIST_BITS], r_rem[DIST_BITS] < r_den[DIST_BITS], "remainder not below divisor")

endmodule

FILE: tb/ray_triangle_intersect_tb.sv
`timescale 1ns / 1ps
module ray_triangle_intersect_tb;
    import rti_pkg::*;

    typedef logic signed [127:0] t_wide;

    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
    localparam int ONE = 4096;
    localparam int PIPE_WAIT = 45;
    localparam int STALL_LIMIT = 4000;
    localparam logic [62:0] ALL_ONES = {63{1'b1}};

    typedef struct {
        logic [62:0] org;
        logic [62:0] dir;
        bit          typed;
        t_out        want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_in              i_item;
    logic             o_valid;
    t_out             o_result;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0] i_cfg_data;

    // Typed expectation travels alongside the ray word.
    bit   row_typed;
    t_out row_want;

    logic [62:0] apex_reg = '0;
    logic [62:0] left_reg = '0;
    logic [62:0] right_reg = '0;
    t_out        hits_pending[$];
    t_row        rows[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          tri_c[3][3];

    ray_triangle_intersect uut (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_wide coord_of(logic [62:0] v, int k);
        logic signed [20:0] c;
        c = v[k*21 +: 21];
        return t_wide'(c);
    endfunction

    function automatic logic [62:0] pack3(int x, int y, int z);
        logic [20:0] a, b, c;
        a = x[20:0];
        b = y[20:0];
        c = z[20:0];
        return {c, b, a};
    endfunction

    // Moller-Trumbore decided exactly on integer numerators.
    function automatic t_out trace_ray(logic [62:0] org, logic [62:0] dir);
        t_wide a[3], e1[3], e2[3], d[3], tv[3], p[3], q[3];
        t_wide det, un, vn, tn, quo;
        t_out  r;
        for (int k = 0; k < 3; k++) begin
            a[k]  = coord_of(apex_reg, k);
            e1[k] = coord_of(left_reg, k) - a[k];
            e2[k] = coord_of(right_reg, k) - a[k];
            d[k]  = coord_of(dir, k);
            tv[k] = coord_of(org, k) - a[k];
        end
        p[0] = d[1] * e2[2] - d[2] * e2[1];
        p[1] = d[2] * e2[0] - d[0] * e2[2];
        p[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = tv[1] * e1[2] - tv[2] * e1[1];
        q[1] = tv[2] * e1[0] - tv[0] * e1[2];
        q[2] = tv[0] * e1[1] - tv[1] * e1[0];
        det = p[0] * e1[0] + p[1] * e1[1] + p[2] * e1[2];
        un  = p[0] * tv[0] + p[1] * tv[1] + p[2] * tv[2];
        vn  = q[0] * d[0] + q[1] * d[1] + q[2] * d[2];
        tn  = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
        r = '0;
        if (det == 0) return r;
        if (det < 0) begin
            det = -det;
            un  = -un;
            vn  = -vn;
            tn  = -tn;
        end
        if (un < 0 || vn < 0 || un + vn >= det || tn <= 0) return r;
        quo = (tn <<< DIST_FRAC) / det;
        r.hit = 1'b1;
        r.distance = (quo > t_wide'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quo[31:0];
        return r;
    endfunction

    function automatic void queue_word(t_out w);
        hits_pending.insert(hits_pending.size(), w);
    endfunction

    function automatic void add_row(logic [62:0] org, logic [62:0] dir, bit typed,
                                    t_out want);
        t_row r;
        r.org = org;
        r.dir = dir;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_APEX:  apex_reg  <= i_cfg_data;
                    REG_LEFT:  left_reg  <= i_cfg_data;
                    REG_RIGHT: right_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !o_busy)
                queue_word(row_typed ? row_want
                                     : trace_ray(i_item.origin_packed,
                                                 i_item.direction_packed));
            if (o_valid) begin
                if (hits_pending.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = hits_pending.pop_front();
                    if (o_result.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_result.hit);
                        errors++;
                    end
                    if (o_result.distance !== want.distance) begin
                        $error("distance: expected %h, got %h",
                               want.distance, o_result.distance);
                        errors++;
                    end
                end
            end
            if ((i_start && !o_busy) || o_valid || i_cfg_we) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_ray(logic [62:0] org, logic [62:0] dir, bit typed, t_out want,
                            int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item.origin_packed <= org;
        i_item.direction_packed <= dir;
        row_typed <= typed;
        row_want <= want;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        row_typed <= 1'b0;
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [62:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_triangle(logic [62:0] a, logic [62:0] l, logic [62:0] r);
        write_reg(REG_APEX, a);
        write_reg(REG_LEFT, l);
        write_reg(REG_RIGHT, r);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_triangle();
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < 3; k++)
                tri_c[v][k] = $urandom_range(16384) - 8192;
        load_triangle(pack3(tri_c[0][0], tri_c[0][1], tri_c[0][2]),
                      pack3(tri_c[1][0], tri_c[1][1], tri_c[1][2]),
                      pack3(tri_c[2][0], tri_c[2][1], tri_c[2][2]));
    endtask

    // Most rays are aimed at a point inside or near the triangle.
    task automatic random_rays(int count, int idle_pct);
        int   o[3], tgt[3], u, v, sh;
        t_out none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) begin
                send_ray(63'({$urandom, $urandom}), 63'({$urandom, $urandom}), 1'b0, none,
                         idle_pct);
            end else begin
                u = $urandom_range(300);
                v = $urandom_range(300 - u);
                sh = ($urandom_range(4) == 0) ? $urandom_range(12) : 0;
                for (int k = 0; k < 3; k++) begin
                    o[k] = $urandom_range(16384) - 8192;
                    tgt[k] = tri_c[0][k] + (u * (tri_c[1][k] - tri_c[0][k])
                             + v * (tri_c[2][k] - tri_c[0][k])) / 256;
                    tgt[k] = (tgt[k] - o[k]) >>> sh;
                    if ($urandom_range(9) == 0) tgt[k] = -tgt[k];
                end
                send_ray(pack3(o[0], o[1], o[2]), pack3(tgt[0], tgt[1], tgt[2]), 1'b0, none,
                         idle_pct);
            end
        end
    endtask

    initial begin
        t_out miss, unit_hit, sat;
        int   idles[4];
        miss = '0;
        unit_hit = '{hit: 1'b1, distance: 32'h0001_0000};
        sat = '{hit: 1'b1, distance: 32'hFFFF_FFFF};
        idles = '{0, 51, 0, 7};
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_APEX;
        i_cfg_data = '0;
        row_typed = 1'b0;
        row_want = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A degenerate triangle straight after reset never hits.
        send_ray(pack3(1024, 1024, -ONE), pack3(0, 0, ONE), 1'b1, miss, 0);
        send_ray(ALL_ONES, ALL_ONES, 1'b1, miss, 0);
        drain();
        tri_c = '{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}};
        load_triangle(pack3(0, 0, 0), pack3(ONE, 0, 0), pack3(0, ONE, 0));
        write_reg(REG_NONE, ALL_ONES);
        i_cfg_we <= 1'b0;

        add_row(pack3(1024, 1024, -ONE), pack3(0, 0, ONE), 1'b1, unit_hit);
        add_row(pack3(1024, 1024, -ONE), pack3(ONE, 0, 0), 1'b1, miss);
        add_row(pack3(1024, 1024, -ONE), pack3(0, 0, 0), 1'b1, miss);
        add_row(pack3(1024, 1024, -ONE), pack3(0, 0, -ONE), 1'b1, miss);
        add_row(pack3(1024, 1024, 0), pack3(0, 0, ONE), 1'b1, miss);
        add_row(pack3(1024, 1024, -1048576), pack3(0, 0, 1), 1'b1, sat);
        add_row(pack3(-1024, 1024, -ONE), pack3(0, 0, ONE), 1'b1, miss);
        add_row(pack3(2048, 2048, -ONE), pack3(0, 0, ONE), 1'b1, miss);
        add_row(pack3(0, 1024, -ONE), pack3(0, 0, ONE), 1'b1, unit_hit);
        add_row(pack3(1024, 1024, -ONE), pack3(0, 0, 3 * ONE), 1'b0, miss);
        add_row(pack3(1000, 7, 5000), pack3(-3, 2, -ONE), 1'b0, miss);
        add_row(ALL_ONES, ALL_ONES, 1'b0, miss);
        add_row(63'd0, ALL_ONES, 1'b0, miss);
        add_row(pack3(1048575, 1048575, 1048575), pack3(-1048576, -1048576, -1048576),
                1'b0, miss);
        add_row(pack3(-1048576, -1048576, -1048576), pack3(1048575, 1048575, 1048575),
                1'b0, miss);
        foreach (rows[i]) send_ray(rows[i].org, rows[i].dir, rows[i].typed, rows[i].want, 0);
        drain();

        // Extreme vertices.
        load_triangle(ALL_ONES, 63'd0, pack3(1048575, -1048576, 1048575));
        foreach (rows[i]) send_ray(rows[i].org, rows[i].dir, 1'b0, miss, 0);
        drain();
        load_triangle(pack3(-1048576, -1048576, -1048576), pack3(1048575, -1048576, 0),
                      pack3(-1048576, 1048575, 1048575));
        random_rays(20, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_triangle();
            random_rays(75, idles[ph % 4]);
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/rti_pkg.sv
design/rti_geom.sv
design/rti_test.sv
design/rti_div.sv
design/ray_triangle_intersect.sv
tb/ray_triangle_intersect_tb.sv
